[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// Each macro samples on the rising edge of clk and is off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SDAS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define SDAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/sdas_pkg.sv]
// ---------------------------------------------------------------------------
// sdas_pkg
// Constants, word types and state codes of the elevator disk arm scheduler.
// ---------------------------------------------------------------------------
package sdas_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TRACK_BITS  = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FIELD_W     = 16;
  localparam int TOTAL_W     = 17;

  typedef logic [TRACK_BITS-1:0] trk_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(QUEUE_DEPTH);

  // Input word kinds
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_RUN = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] track;
    logic [FIELD_W-1:0] head_start;
    logic               upward;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] served_track;
    logic [FIELD_W-1:0] move_distance;
    logic [TOTAL_W-1:0] total_movement;
    logic               last_of_run;
    logic               none_pending;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

[rtl/core/sdas_if.sv]
// ---------------------------------------------------------------------------
// sdas_if
// Valid/ready channels for request words and service result words.
// ---------------------------------------------------------------------------
interface sdas_in_if;
  import sdas_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdas_out_if;
  import sdas_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/sdas_ram.sv]
// ---------------------------------------------------------------------------
// sdas_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module sdas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/scan_disk_arm_scheduler.sv]
// ---------------------------------------------------------------------------
// scan_disk_arm_scheduler
// Elevator (SCAN) disk arm scheduler over a table of pending track requests.
// ---------------------------------------------------------------------------
// Usage:
//   in_s  : request words. kind = add queues track (dropped when the table is
//           full); kind = run starts a sweep from head_start toward upward.
//   out_s : one result word per served request, nearest first in the sweep
//           direction, then the rest after the turn; last_of_run marks the
//           final one. A run with an empty table gives one word with
//           none_pending and last_of_run set and all other fields zero.
//   During a run each service takes one pass over the table held in RAM: the
//   reads of the entries, one entry per cycle, then the registered read, the
//   settle of the last compare and the decide state; the one service at the
//   turn takes two passes. Stalls of the receiver lengthen the run.
//   in_s.ready is low from the run word until the last result is loaded into
//   the output register. A stalled receiver holds the current result; the
//   next pass still runs, and its result waits for the register to empty.
//   Reset empties the table, clears output valid, sets the head to track zero
//   and the direction to upward. Each add writes its served mark as clear.
// ---------------------------------------------------------------------------
module scan_disk_arm_scheduler (
  input logic        clk,
  input logic        rst_n,
  sdas_in_if.sink    in_s,
  sdas_out_if.source out_s
);

  import sdas_pkg::*;

  state_t                 state_r, state_nxt;
  cnt_t                   pend_r;
  trk_t                   head_r;
  logic                   up_r;
  logic [TOTAL_W-1:0]     total_r;
  cnt_t                   issue_r;
  logic                   rd_vld_r;
  idx_t                   rd_idx_r;
  logic                   found_r;
  trk_t                   best_trk_r;
  idx_t                   best_idx_r;
  cnt_t                   served_r;
  out_word_t              out_r;
  logic                   out_vld_r;

  logic                   in_take, run_take;
  logic                   out_free;
  logic                   issue_more, scan_done;
  trk_t                   rd_trk;
  logic                   rd_mark;
  logic                   cand_dir, cand_better, take_cand;
  trk_t                   move_d;
  logic [TOTAL_W-1:0]     total_sum;
  logic                   last_svc;
  logic                   ram_we;
  logic                   issue_en, load_svc, load_empty, rescan, finish;
  logic                   tbl_we;
  idx_t                   tbl_waddr;
  logic [TRACK_BITS:0]    tbl_wdata;
  logic [TRACK_BITS:0]    tbl_rdata;

  // Request table: served mark in the top bit, track below it
  sdas_ram #(
    .WIDTH (TRACK_BITS + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  assign rd_mark = tbl_rdata[TRACK_BITS];
  assign rd_trk  = tbl_rdata[TRACK_BITS-1:0];

  // Handshake terms
  assign in_take    = in_s.valid && in_s.ready;
  assign run_take   = in_take && (in_s.data.kind == KIND_RUN);
  assign out_free   = !out_vld_r || out_s.ready;
  assign issue_more = issue_r < pend_r;
  assign scan_done  = !issue_more && !rd_vld_r;

  // Compare the entry read back against the best one so far
  assign cand_dir    = up_r ? (rd_trk >= head_r) : (rd_trk <= head_r);
  assign cand_better = !found_r || (up_r ? (rd_trk < best_trk_r) : (rd_trk > best_trk_r));
  assign take_cand   = rd_vld_r && !rd_mark && cand_dir && cand_better;

  // Head movement for the chosen request
  assign move_d    = (best_trk_r >= head_r) ? (best_trk_r - head_r) : (head_r - best_trk_r);
  assign total_sum = total_r + TOTAL_W'(move_d);
  assign last_svc  = (cnt_t'(served_r + 1'b1) == pend_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (run_take) begin
          state_nxt = (pend_r == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!found_r) begin
          state_nxt = ST_SCAN;
        end else if (out_free) begin
          state_nxt = last_svc ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State decode
  always_comb begin
    in_s.ready = (state_r == ST_IDLE);
    ram_we     = in_take && (in_s.data.kind == KIND_ADD) && (pend_r < DEPTH_CNT);
    issue_en   = (state_r == ST_SCAN) && issue_more;
    load_svc   = (state_r == ST_DECIDE) && found_r && out_free;
    load_empty = (state_r == ST_EMPTY) && out_free;
    rescan     = (state_r == ST_DECIDE) && (!found_r || (out_free && !last_svc));
    finish     = load_svc && last_svc;
  end

  // Table write: an add stores a clear mark, a service sets the mark
  assign tbl_we    = ram_we || load_svc;
  assign tbl_waddr = load_svc ? best_idx_r : pend_r[IDX_W-1:0];
  assign tbl_wdata = load_svc ? {1'b1, best_trk_r}
                              : {1'b0, in_s.data.track[TRACK_BITS-1:0]};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pend_r    <= '0;
      head_r    <= '0;
      up_r      <= 1'b1;
      total_r   <= '0;
      issue_r   <= '0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      served_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue_en;

      // Fill the table, and empty it when the last service of a run is loaded
      if (ram_we) begin
        pend_r <= cnt_t'(pend_r + 1'b1);
      end else if (finish) begin
        pend_r <= '0;
      end

      // Start a run: load head, direction and total
      if (run_take) begin
        head_r   <= in_s.data.head_start[TRACK_BITS-1:0];
        up_r     <= in_s.data.upward;
        total_r  <= '0;
        served_r <= '0;
      end else if (load_svc) begin
        head_r   <= best_trk_r;
        total_r  <= total_sum;
        served_r <= cnt_t'(served_r + 1'b1);
      end else if ((state_r == ST_DECIDE) && !found_r) begin
        up_r <= ~up_r;
      end

      // Walk the table
      if (run_take || rescan) begin
        issue_r <= '0;
        found_r <= 1'b0;
      end else begin
        if (issue_en) begin
          issue_r <= cnt_t'(issue_r + 1'b1);
        end
        if (take_cand) begin
          found_r <= 1'b1;
        end
      end

      // Output register valid
      if (load_svc || load_empty) begin
        out_vld_r <= 1'b1;
      end else if (out_s.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= issue_r[IDX_W-1:0];
    if (take_cand) begin
      best_trk_r <= rd_trk;
      best_idx_r <= rd_idx_r;
    end
    if (load_svc) begin
      out_r.served_track   <= FIELD_W'(best_trk_r);
      out_r.move_distance  <= FIELD_W'(move_d);
      out_r.total_movement <= total_sum;
      out_r.last_of_run    <= last_svc;
      out_r.none_pending   <= 1'b0;
    end else if (load_empty) begin
      out_r.served_track   <= '0;
      out_r.move_distance  <= '0;
      out_r.total_movement <= '0;
      out_r.last_of_run    <= 1'b1;
      out_r.none_pending   <= 1'b1;
    end
  end

  assign out_s.valid = out_vld_r;
  assign out_s.data  = out_r;

endmodule

[rtl/core/sdas_checker.sv]
// ---------------------------------------------------------------------------
// sdas_checker
// Port-level checks of the elevator scheduler, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sdas_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_kind,
  input logic                out_valid,
  input logic                out_ready,
  input sdas_pkg::out_word_t out_data
);

  import sdas_pkg::*;

  logic run_acc, mid_acc, empty_word;

  assign run_acc    = in_valid && in_ready && (in_kind == KIND_RUN);
  assign mid_acc    = out_valid && out_ready && !out_data.last_of_run;
  assign empty_word = out_data.served_track == '0 && out_data.move_distance == '0 &&
                      out_data.total_movement == '0 && out_data.last_of_run;

  // Hold a stalled result word
  `SDAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // An empty-run word is the only word of its run and carries zeros
  `SDAS_ASSERT_NOW(a_empty_word, out_valid && out_data.none_pending, empty_word)

  // Block new words once a run starts
  `SDAS_ASSERT_NEXT(a_run_blocks, run_acc, !in_ready)

  // Keep blocking while a word short of the run's last one is handed over
  `SDAS_ASSERT_NOW(a_mid_blocks, mid_acc, !in_ready)

endmodule

bind scan_disk_arm_scheduler sdas_checker u_sdas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_kind   (in_s.data.kind),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_data  (out_s.data)
);
